FILE: rtl/fdq_pkg.sv
// Shared constants and codes for the fader deadband quantizer.
package fdq_pkg;

	localparam int CHANNELS_DEF = 8;

	localparam int CMD_W   = 2;
	localparam int CHAN_W  = 4;
	localparam int RAW_W   = 12;
	localparam int LEVEL_W = 7;
	localparam int THR_W   = 7;
	localparam int PROD_W  = RAW_W + LEVEL_W;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [LEVEL_W-1:0] SCALE_TOP = 7'd127;

	localparam logic [RAW_W-1:0] FULL_SCALE_RST = 12'd4095;
	localparam logic [THR_W-1:0] THRESHOLD_RST  = 7'd1;

	// register index = paddr[2]
	localparam logic REG_FULL_SCALE = 1'b0;
	localparam logic REG_THRESHOLD  = 1'b1;

	localparam logic [CMD_W-1:0] CMD_SAMPLE     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ_LEVEL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ_CLEAR = 2'd2;

endpackage

FILE: rtl/fader_deadband_quantizer.sv
// Top level of the fader deadband quantizer: stream in, APB registers, result out.
//
// Each input beat carries a command, a channel and a raw ADC reading. A sample
// clamps the reading to full_scale, scales it to 0..127 as reading*127/full_scale
// and, when it differs from the channel's stored level by more than
// change_threshold, replaces the level and sets the channel's sticky changed
// flag; a sample returns no beat. A level query returns the stored level, a
// flag query returns the changed flag and clears it; queries to a channel at or
// above CHANNELS return 0, and command 3 is dropped. Level and flag of all
// channels live in one small RAM with registered read; a valid bit per channel,
// cleared by reset, makes an unwritten channel read as zero, so no clearing
// pass is needed after reset. The block works on one beat at a time. A sample
// passes the start state (take the RAM data, load the divider), the divide state
// (bit-serial division by full_scale, wait for the divider's registered done
// flag) and the update state (compare, write back) before the next ready. A
// query passes the query state (modify and write back) and the result state
// (load the output register), holding in the latter while the output register
// still owns an untaken beat; the output register lets the next beat enter while
// a result waits to be taken. Write the registers only while the block is idle.
module fader_deadband_quantizer #(
	parameter int CHANNELS = fdq_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// stream in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] command, [5:2] channel, [17:6] raw_sample, [23:18] zero
	input  logic [fdq_pkg::IN_DATA_W-1:0]   s_tdata,
	// stream out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [6:0] read_value, [7] zero
	output logic [fdq_pkg::OUT_DATA_W-1:0]  m_tdata,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fdq_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [fdq_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [fdq_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import fdq_pkg::*;

	localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ENT_W = LEVEL_W + 1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_QUERY  = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	// Configuration registers
	logic [RAW_W-1:0] full_scale_q;
	logic [THR_W-1:0] threshold_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
			threshold_q  <= THRESHOLD_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FULL_SCALE: full_scale_q <= pwdata[RAW_W-1:0];
				REG_THRESHOLD:  threshold_q  <= pwdata[THR_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FULL_SCALE: prdata = APB_DATA_W'(full_scale_q);
			REG_THRESHOLD:  prdata = APB_DATA_W'(threshold_q);
			default:        prdata = '0;
		endcase
	end

	// Input unpacking
	logic [CMD_W-1:0]  in_command;
	logic [CHAN_W-1:0] in_channel;
	logic [RAW_W-1:0]  in_raw;
	logic              in_accept;
	logic              in_chan_ok;
	logic [RAW_W-1:0]  clamped;

	assign in_command = s_tdata[CMD_W-1:0];
	assign in_channel = s_tdata[CMD_W +: CHAN_W];
	assign in_raw     = s_tdata[CMD_W+CHAN_W +: RAW_W];
	assign in_accept  = s_tvalid & s_tready;
	assign in_chan_ok = {1'b0, in_channel} < (CHAN_W+1)'(CHANNELS);
	assign clamped    = (in_raw > full_scale_q) ? full_scale_q : in_raw;

	// Control and item registers
	logic [2:0]         state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [AW-1:0]      addr_q;
	logic               chan_ok_q;
	logic [PROD_W-1:0]  product_q;
	logic [LEVEL_W-1:0] old_level_q;
	logic [LEVEL_W-1:0] result_q;
	logic [LEVEL_W-1:0] out_value_q;
	logic               out_valid_q;
	logic [CHANNELS-1:0] written_q;

	// RAM: entry = {changed flag, stored level}
	logic               ram_we;
	logic [ENT_W-1:0]   ram_wdata;
	logic [ENT_W-1:0]   ram_rdata;
	logic [ENT_W-1:0]   entry;

	fdq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (in_channel[AW-1:0]),
		.rdata (ram_rdata)
	);

	// An entry never written since reset reads as zero
	assign entry = written_q[addr_q] ? ram_rdata : '0;

	// Divider
	logic               div_start;
	logic               div_done;
	logic [LEVEL_W-1:0] quotient;

	assign div_start = (state_q == ST_START);

	fdq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product_q),
		.divisor  (full_scale_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Compare against the stored level
	logic [LEVEL_W-1:0] new_level;
	logic [LEVEL_W-1:0] diff;
	logic               over;

	// Zero full scale clamps every reading to zero; skip the divider result
	assign new_level = (full_scale_q == '0) ? '0 : quotient;
	assign diff      = (new_level > old_level_q) ? new_level - old_level_q
	                                             : old_level_q - new_level;
	assign over      = diff > threshold_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = entry;
		if (state_q == ST_UPDATE && over) begin
			ram_we    = 1'b1;
			ram_wdata = {1'b1, new_level};
		end else if (state_q == ST_QUERY && chan_ok_q && cmd_q == CMD_READ_CLEAR) begin
			ram_we    = 1'b1;
			ram_wdata = {1'b0, entry[LEVEL_W-1:0]};
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q     <= in_command;
			addr_q    <= in_channel[AW-1:0];
			chan_ok_q <= in_chan_ok;
			product_q <= PROD_W'(clamped) * PROD_W'(SCALE_TOP);
		end
		if (state_q == ST_START) begin
			old_level_q <= entry[LEVEL_W-1:0];
		end
		if (state_q == ST_QUERY) begin
			if (!chan_ok_q) begin
				result_q <= '0;
			end else if (cmd_q == CMD_READ_CLEAR) begin
				result_q <= LEVEL_W'(entry[LEVEL_W]);
			end else begin
				result_q <= entry[LEVEL_W-1:0];
			end
		end
		if (state_q == ST_RESULT && (!out_valid_q || m_tready)) begin
			out_value_q <= result_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			written_q   <= '0;
		end else begin
			if (ram_we) begin
				written_q[addr_q] <= 1'b1;
			end

			// Hand off the waiting beat, or load the next one in its place
			if (state_q == ST_RESULT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						priority if (in_command == CMD_SAMPLE) begin
							state_q <= in_chan_ok ? ST_START : ST_IDLE;
						end else if (in_command == CMD_READ_LEVEL ||
						             in_command == CMD_READ_CLEAR) begin
							state_q <= ST_QUERY;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_START:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: state_q <= ST_IDLE;
				ST_QUERY:  state_q <= ST_RESULT;
				ST_RESULT: begin
					if (!out_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_value_q};

endmodule

FILE: rtl/fdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fdq_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 8,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/fdq_divider.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit in 7 bits.
module fdq_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [fdq_pkg::PROD_W-1:0]         dividend,
	input  logic [fdq_pkg::RAW_W-1:0]          divisor,
	output logic                               done,
	output logic [fdq_pkg::LEVEL_W-1:0]        quotient
);
	import fdq_pkg::*;

	localparam int CNT_W = $clog2(LEVEL_W + 1);

	logic [RAW_W-1:0]   rem_q;
	logic [RAW_W-1:0]   dvs_q;
	logic [LEVEL_W-1:0] low_q;
	logic [LEVEL_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	logic [RAW_W:0]     trial;
	logic               fits;

	// Dividend < 128 * divisor, so the top bits already sit below the divisor.
	assign trial = {rem_q, low_q[LEVEL_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:LEVEL_W];
			low_q <= dividend[LEVEL_W-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? RAW_W'(trial - {1'b0, dvs_q}) : trial[RAW_W-1:0];
			low_q <= {low_q[LEVEL_W-2:0], 1'b0};
			quo_q <= {quo_q[LEVEL_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(LEVEL_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: test/fader_deadband_quantizer_tb.sv
// Self-checking stream/APB testbench for the fader deadband quantizer.
module fader_deadband_quantizer_tb;
	import fdq_pkg::*;

	localparam int LIVE_CHANNELS = CHANNELS_DEF;
	localparam int IDX_W = (LIVE_CHANNELS > 1) ? $clog2(LIVE_CHANNELS) : 1;
	localparam int CYCLE_LIMIT = 200000;
	// Samples return no beat: give the divider this long to finish before a register write.
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD_CYCLES = 300;
	// The fourth command code carries no meaning; the block drops it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	// [1:0] command, [5:2] channel, [17:6] raw_sample, [23:18] zero
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [6:0] read_value, [7] zero
	logic [OUT_DATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	fader_deadband_quantizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Commands waiting for the driver, and read values the block still owes us.
	logic [IN_DATA_W-1:0] queued_commands[$];
	logic [LEVEL_W-1:0] owed_read_values[$];

	// Our own copy of the register file and the per-fader state.
	logic [RAW_W-1:0] full_scale_cfg = FULL_SCALE_RST;
	logic [THR_W-1:0] threshold_cfg = THRESHOLD_RST;
	logic [LEVEL_W-1:0] fader_level[LIVE_CHANNELS];
	logic fader_changed[LIVE_CHANNELS];

	int commands_queued = 0;
	int commands_taken = 0;
	int error_count = 0;
	int cycle_count = 0;

	// Traffic shaping knobs, set by the stimulus and read by the driver and receiver.
	bit idling_on = 1'b1;
	bit long_hold_req = 1'b0;
	bit in_fire = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Scale a raw ADC code to 0..127 against the current full scale.
	function automatic logic [LEVEL_W-1:0] scale_to_level(input logic [RAW_W-1:0] raw);
		logic [RAW_W-1:0] clamped;
		logic [PROD_W-1:0] product;
		if (full_scale_cfg == '0) begin
			return '0;
		end
		clamped = (raw > full_scale_cfg) ? full_scale_cfg : raw;
		product = PROD_W'(clamped) * PROD_W'(SCALE_TOP);
		return LEVEL_W'(product / PROD_W'(full_scale_cfg));
	endfunction

	// Advance the fader state by one accepted command and note any read value it owes.
	task automatic track_fader_command(input logic [IN_DATA_W-1:0] beat);
		logic [CMD_W-1:0] cmd;
		logic [CHAN_W-1:0] ch;
		logic [IDX_W-1:0] idx;
		logic [RAW_W-1:0] raw;
		logic in_range;
		logic [LEVEL_W-1:0] new_level;
		logic [LEVEL_W-1:0] distance;
		cmd = beat[1:0];
		ch = beat[5:2];
		idx = ch[IDX_W-1:0];
		raw = beat[17:6];
		in_range = (int'(ch) < LIVE_CHANNELS);
		case (cmd)
			CMD_SAMPLE: begin
				if (in_range) begin
					new_level = scale_to_level(raw);
					distance = (new_level > fader_level[idx]) ? new_level - fader_level[idx]
						: fader_level[idx] - new_level;
					if (distance > threshold_cfg) begin
						fader_level[idx] = new_level;
						fader_changed[idx] = 1'b1;
					end
				end
			end
			CMD_READ_LEVEL: begin
				owed_read_values.push_back(in_range ? fader_level[idx] : '0);
			end
			CMD_READ_CLEAR: begin
				if (in_range) begin
					owed_read_values.push_back(LEVEL_W'(fader_changed[idx]));
					fader_changed[idx] = 1'b0;
				end else begin
					owed_read_values.push_back('0);
				end
			end
			default: begin
				// unused code: dropped, no beat back
			end
		endcase
	endtask

	// Driver: present the next queued command at the falling edge once the slot is free,
	// with random gaps between beats while idling is on.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_fire) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (queued_commands.size() > 0) begin
					s_tdata <= queued_commands.pop_front();
					s_tvalid <= 1'b1;
					if (idling_on && $urandom_range(0, 3) == 0) begin
						gap_left = $urandom_range(1, 5);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request so that the
	// output register fills and the block has to stall its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idling_on && $urandom_range(0, 3) == 0) begin
					stall_left = $urandom_range(1, 5);
				end
			end
		end
	end

	// Monitor: check the result beat against the oldest owed value, then feed the
	// accepted command beat to the predictor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (owed_read_values.size() == 0) begin
					report_mismatch($sformatf("result beat 0x%02h with nothing owed", m_tdata));
				end else begin
					logic [LEVEL_W-1:0] owed;
					owed = owed_read_values.pop_front();
					if (m_tdata[LEVEL_W-1:0] !== owed) begin
						report_mismatch($sformatf("read_value %0d, expected %0d",
							m_tdata[LEVEL_W-1:0], owed));
					end
					if (m_tdata[OUT_DATA_W-1:LEVEL_W] !== '0) begin
						report_mismatch("pad bits of result beat not zero");
					end
				end
			end
			in_fire = s_tvalid && s_tready;
			if (in_fire) begin
				track_fader_command(s_tdata);
				commands_taken++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fader_deadband_quantizer_tb: FAIL");
			$finish;
		end
	end

	task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
		input logic [RAW_W-1:0] raw);
		queued_commands.push_back({6'b0, raw, ch, cmd});
		commands_queued++;
	endtask

	// Pick a reading: uniform, the extremes, around the clamp point, or near the
	// code of a random level so that differences land close to the threshold.
	function automatic logic [RAW_W-1:0] pick_raw();
		int mode;
		int code;
		mode = $urandom_range(0, 7);
		case (mode)
			0: return '0;
			1: return '1;
			2: begin
				code = int'(full_scale_cfg) + $urandom_range(0, 6) - 3;
				return RAW_W'((code < 0) ? 0 : (code > 4095) ? 4095 : code);
			end
			3, 4: begin
				code = ($urandom_range(0, 127) * int'(full_scale_cfg)) / 127
					+ $urandom_range(0, 4) - 2;
				return RAW_W'((code < 0) ? 0 : (code > 4095) ? 4095 : code);
			end
			default: return RAW_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// Queue a batch of random commands; query_pct sets the share of queries.
	task automatic queue_random_commands(input int count, input int query_pct);
		logic [CMD_W-1:0] cmd;
		logic [CHAN_W-1:0] ch;
		int roll;
		@(posedge clk);
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				cmd = CMD_UNUSED;
			end else if (roll < 4 + query_pct) begin
				cmd = $urandom_range(0, 1) ? CMD_READ_LEVEL : CMD_READ_CLEAR;
			end else begin
				cmd = CMD_SAMPLE;
			end
			// mostly live faders, some out of range
			if ($urandom_range(0, 99) < 85) begin
				ch = CHAN_W'($urandom_range(0, LIVE_CHANNELS - 1));
			end else begin
				ch = CHAN_W'($urandom_range(LIVE_CHANNELS, 15));
			end
			queue_command(cmd, ch, pick_raw());
		end
	endtask

	// Wait until every command is taken and every owed value returned, then let a
	// trailing sample finish its division.
	task automatic settle_block();
		do @(negedge clk);
		while (commands_taken != commands_queued || owed_read_values.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Two-phase APB write; the shadow register follows at the write edge, and the
	// read data must show the new value right after it.
	task automatic write_register(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] expected;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (reg_sel == REG_FULL_SCALE) begin
			full_scale_cfg = value[RAW_W-1:0];
			expected = APB_DATA_W'(value[RAW_W-1:0]);
		end else begin
			threshold_cfg = value[THR_W-1:0];
			expected = APB_DATA_W'(value[THR_W-1:0]);
		end
		@(negedge clk);
		if (prdata !== expected) begin
			report_mismatch($sformatf("register read 0x%08h, expected 0x%08h",
				prdata, expected));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Set both registers; junk above the field widths must be ignored.
	task automatic set_registers(input int full_scale, input int threshold);
		settle_block();
		write_register(REG_FULL_SCALE, {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0,
			RAW_W'(full_scale)});
		write_register(REG_THRESHOLD, {$urandom_range(0, 1) ? 25'h1FFFFFF : 25'h0,
			THR_W'(threshold)});
	endtask

	initial begin
		for (int i = 0; i < LIVE_CHANNELS; i++) begin
			fader_level[i] = '0;
			fader_changed[i] = 1'b0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset values (full scale 4095, threshold 1).
		@(posedge clk);
		queue_command(CMD_SAMPLE, 4'd0, 12'd4095);       // full scale reading -> 127
		queue_command(CMD_READ_LEVEL, 4'd0, 12'd0);
		queue_command(CMD_READ_CLEAR, 4'd0, 12'd0);      // flag set, now cleared
		queue_command(CMD_READ_CLEAR, 4'd0, 12'd0);
		queue_command(CMD_SAMPLE, 4'd7, 12'd33);         // scales to 1: not past threshold
		queue_command(CMD_READ_LEVEL, 4'd7, 12'd0);
		queue_command(CMD_READ_CLEAR, 4'd7, 12'd0);
		queue_command(CMD_SAMPLE, 4'd7, 12'd97);         // scales to 3: updates
		queue_command(CMD_READ_LEVEL, 4'd7, 12'd0);
		queue_command(CMD_SAMPLE, 4'd8, 12'd4095);       // out-of-range sample: dropped
		queue_command(CMD_READ_LEVEL, 4'd8, 12'd0);
		queue_command(CMD_SAMPLE, 4'd15, 12'hFFF);
		queue_command(CMD_READ_LEVEL, 4'd15, 12'hFFF);
		queue_command(CMD_READ_CLEAR, 4'd15, 12'hFFF);   // out of range: clears nothing
		queue_command(CMD_UNUSED, 4'd1, 12'd4095);       // dropped, no effect
		queue_command(CMD_READ_LEVEL, 4'd1, 12'd0);
		queue_command(CMD_SAMPLE, 4'd1, 12'hAAA);
		queue_command(CMD_SAMPLE, 4'd2, 12'h555);
		queue_command(CMD_READ_LEVEL, 4'd1, 12'd0);
		queue_command(CMD_READ_LEVEL, 4'd2, 12'd0);
		queue_command(CMD_READ_CLEAR, 4'd1, 12'd0);
		queue_command(CMD_SAMPLE, 4'd0, 12'd0);          // 127 -> 0
		queue_command(CMD_READ_LEVEL, 4'd0, 12'd0);
		queue_command(CMD_READ_CLEAR, 4'd2, 12'd0);

		// Smallest full scale: every nonzero reading is full level.
		set_registers(1, 0);
		queue_random_commands(60, 45);

		// Zero full scale: everything scales to zero, the divider result is not used.
		set_registers(0, 0);
		queue_random_commands(55, 45);

		// Threshold at its top: stored levels freeze.
		set_registers(4095, 127);
		queue_random_commands(55, 45);

		// Query-heavy batch under a long receiver hold-off; input must stall.
		set_registers($urandom_range(1, 4095), $urandom_range(0, 20));
		@(posedge clk);
		long_hold_req = 1'b1;
		queue_random_commands(60, 80);

		// A stretch with no idling at all.
		set_registers(2000, 3);
		@(posedge clk);
		idling_on = 1'b0;
		queue_random_commands(55, 45);

		set_registers($urandom_range(1, 4095), $urandom_range(0, 127));
		@(posedge clk);
		idling_on = 1'b1;
		queue_random_commands(60, 45);

		set_registers(127, 2);
		queue_random_commands(55, 45);

		// Last part: full range, zero threshold, no idling on either side.
		set_registers(4095, 0);
		@(posedge clk);
		idling_on = 1'b0;
		queue_random_commands(55, 45);

		settle_block();
		if (error_count == 0) begin
			$display("fader_deadband_quantizer_tb: PASS");
		end else begin
			$display("fader_deadband_quantizer_tb: FAIL");
		end
		$finish;
	end

endmodule
